>>> rtl/dsb_pkg.sv
// shared types and codes of the draw item sorter and batcher
package dsb_pkg;

	typedef enum logic [1:0] {
		STATUS_OK       = 2'd0,
		STATUS_RESOLVE  = 2'd1,
		STATUS_OVERFLOW = 2'd2
	} status_t;

	typedef enum logic {
		KIND_BATCH    = 1'b0,
		KIND_INSTANCE = 1'b1
	} kind_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_SCAN,
		BK_BATCH,
		BK_INST,
		BK_ERR
	} back_state_t;

	localparam logic [5:0] LIMIT_RESET = 6'd32;

	typedef struct packed {
		logic [31:0] pipe_key;
		logic [31:0] material_handle;
		logic [31:0] mesh_handle;
		logic        resolve_ok;
		logic        is_last;
	} item_t;

	typedef struct packed {
		logic        kind;
		logic [1:0]  status;
		logic [4:0]  source_index;
		logic [31:0] batch_pipe_key;
		logic [31:0] batch_material;
		logic [31:0] batch_mesh;
		logic [4:0]  first_slot;
		logic [5:0]  instance_total;
		logic        last_result;
	} result_t;

	// handoff of a finished list from the front to the back
	typedef struct packed {
		logic    load;
		status_t status;
	} handoff_t;

endpackage

>>> rtl/dsb_front.sv
// front: takes draw items and keeps them in a sorted row of cells
module dsb_front import dsb_pkg::*; #(
	parameter int MAX_ITEMS = 32,
	parameter int SW        = 32,
	parameter int IW        = 5,
	parameter int CW        = 6
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [5:0]                      cfg_wdata,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  item_t                           in_data,
	input  logic                            back_busy,
	output handoff_t                        hand,
	output logic [CW-1:0]                   hand_count,
	output logic [MAX_ITEMS-1:0][31:0]      nxt_key,
	output logic [MAX_ITEMS-1:0][SW-1:0]    nxt_mat,
	output logic [MAX_ITEMS-1:0][SW-1:0]    nxt_mesh,
	output logic [MAX_ITEMS-1:0][IW-1:0]    nxt_idx
);

	localparam int TW = 32 + 2 * SW;

	logic [5:0]                   item_limit_q;
	logic [CW-1:0]                count_q;
	logic                         resolve_failed_q;
	logic                         overflowed_q;
	logic [MAX_ITEMS-1:0][31:0]   key_q;
	logic [MAX_ITEMS-1:0][SW-1:0] mat_q;
	logic [MAX_ITEMS-1:0][SW-1:0] mesh_q;
	logic [MAX_ITEMS-1:0][IW-1:0] idx_q;
	logic [MAX_ITEMS-1:0]         le;
	logic [TW-1:0]                new_trip;
	logic                         accept;
	logic                         store_en;
	logic                         ovf_nxt;
	logic                         rf_nxt;

	assign accept   = in_valid && in_ready;
	assign in_ready = !(in_data.is_last && back_busy);
	assign store_en = (7'(count_q) < 7'(item_limit_q)) && (count_q < CW'(MAX_ITEMS));
	assign new_trip = {in_data.pipe_key, in_data.material_handle[SW-1:0],
		in_data.mesh_handle[SW-1:0]};

	// a stored cell stays put when it sorts at or before the new item
	for (genvar g = 0; g < MAX_ITEMS; g++) begin : g_cell
		assign le[g] = (CW'(g) < count_q) &&
			({key_q[g], mat_q[g], mesh_q[g]} <= new_trip);
		if (g == 0) begin : g_first
			always_comb begin
				nxt_key[g]  = key_q[g];
				nxt_mat[g]  = mat_q[g];
				nxt_mesh[g] = mesh_q[g];
				nxt_idx[g]  = idx_q[g];
				if (store_en && !le[g]) begin
					nxt_key[g]  = in_data.pipe_key;
					nxt_mat[g]  = in_data.material_handle[SW-1:0];
					nxt_mesh[g] = in_data.mesh_handle[SW-1:0];
					nxt_idx[g]  = count_q[IW-1:0];
				end
			end
		end else begin : g_rest
			always_comb begin
				nxt_key[g]  = key_q[g];
				nxt_mat[g]  = mat_q[g];
				nxt_mesh[g] = mesh_q[g];
				nxt_idx[g]  = idx_q[g];
				if (store_en && !le[g]) begin
					if (le[g-1]) begin
						nxt_key[g]  = in_data.pipe_key;
						nxt_mat[g]  = in_data.material_handle[SW-1:0];
						nxt_mesh[g] = in_data.mesh_handle[SW-1:0];
						nxt_idx[g]  = count_q[IW-1:0];
					end else begin
						nxt_key[g]  = key_q[g-1];
						nxt_mat[g]  = mat_q[g-1];
						nxt_mesh[g] = mesh_q[g-1];
						nxt_idx[g]  = idx_q[g-1];
					end
				end
			end
		end
	end

	assign ovf_nxt = overflowed_q || !store_en;
	assign rf_nxt  = resolve_failed_q || !in_data.resolve_ok;

	always_comb begin
		hand.load   = accept && in_data.is_last;
		hand.status = ovf_nxt ? STATUS_OVERFLOW : (rf_nxt ? STATUS_RESOLVE : STATUS_OK);
		hand_count  = store_en ? count_q + CW'(1) : count_q;
	end

	always_ff @(posedge clk) begin
		if (accept && store_en) begin
			key_q  <= nxt_key;
			mat_q  <= nxt_mat;
			mesh_q <= nxt_mesh;
			idx_q  <= nxt_idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_limit_q     <= LIMIT_RESET;
			count_q          <= '0;
			resolve_failed_q <= 1'b0;
			overflowed_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				item_limit_q <= cfg_wdata;
			end
			if (accept) begin
				if (in_data.is_last) begin
					count_q          <= '0;
					resolve_failed_q <= 1'b0;
					overflowed_q     <= 1'b0;
				end else begin
					count_q          <= hand_count;
					resolve_failed_q <= rf_nxt;
					overflowed_q     <= ovf_nxt;
				end
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_ITEMS))
		else $error("item count beyond capacity");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		hand.load |=> count_q == '0 && !overflowed_q && !resolve_failed_q)
		else $error("run state not cleared after last item");

endmodule

>>> rtl/dsb_back.sv
// back: walks a sorted list and emits batch and instance records
module dsb_back import dsb_pkg::*; #(
	parameter int MAX_ITEMS = 32,
	parameter int SW        = 32,
	parameter int IW        = 5,
	parameter int CW        = 6
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  handoff_t                        hand,
	input  logic [CW-1:0]                   hand_count,
	input  logic [MAX_ITEMS-1:0][31:0]      nxt_key,
	input  logic [MAX_ITEMS-1:0][SW-1:0]    nxt_mat,
	input  logic [MAX_ITEMS-1:0][SW-1:0]    nxt_mesh,
	input  logic [MAX_ITEMS-1:0][IW-1:0]    nxt_idx,
	output logic                            busy,
	output logic                            out_valid,
	input  logic                            out_ready,
	output result_t                         out_data
);

	back_state_t                  state_q, state_nxt;
	logic [MAX_ITEMS-1:0][31:0]   key_q;
	logic [MAX_ITEMS-1:0][SW-1:0] mat_q;
	logic [MAX_ITEMS-1:0][SW-1:0] mesh_q;
	logic [MAX_ITEMS-1:0][IW-1:0] idx_q;
	logic [MAX_ITEMS-1:0]         same_q;
	logic [CW-1:0]                n_q;
	status_t                      err_q;
	logic [IW-1:0]                start_q;
	logic [IW-1:0]                p_q;
	logic [IW-1:0]                run_last_q;
	logic                         out_valid_q;
	result_t                      out_data_q;
	logic                         slot_free;
	logic                         more;
	logic                         run_end;
	logic                         list_end;
	logic                         emit;
	result_t                      emit_data;

	assign slot_free = !out_valid_q || out_ready;
	assign more      = ((CW'(p_q) + CW'(1)) < n_q) && same_q[p_q + IW'(1)];
	assign run_end   = p_q == run_last_q;
	assign list_end  = (CW'(p_q) + CW'(1)) == n_q;
	assign busy      = state_q != BK_IDLE;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			BK_IDLE: begin
				if (hand.load) begin
					state_nxt = (hand.status != STATUS_OK) ? BK_ERR : BK_SCAN;
				end
			end
			BK_SCAN: begin
				if (!more) begin
					state_nxt = BK_BATCH;
				end
			end
			BK_BATCH: begin
				if (slot_free) begin
					state_nxt = BK_INST;
				end
			end
			BK_INST: begin
				if (slot_free && run_end) begin
					state_nxt = list_end ? BK_IDLE : BK_SCAN;
				end
			end
			BK_ERR: begin
				if (slot_free) begin
					state_nxt = BK_IDLE;
				end
			end
			default: state_nxt = BK_IDLE;
		endcase
	end

	always_comb begin
		emit      = 1'b0;
		emit_data = '0;
		case (state_q)
			BK_BATCH: begin
				emit                     = slot_free;
				emit_data.kind           = KIND_BATCH;
				emit_data.status         = STATUS_OK;
				emit_data.batch_pipe_key = key_q[start_q];
				emit_data.batch_material = 32'(mat_q[start_q]);
				emit_data.batch_mesh     = 32'(mesh_q[start_q]);
				emit_data.first_slot     = 5'(start_q);
				emit_data.instance_total = 6'(CW'(run_last_q) - CW'(start_q) + CW'(1));
			end
			BK_INST: begin
				emit                   = slot_free;
				emit_data.kind         = KIND_INSTANCE;
				emit_data.status       = STATUS_OK;
				emit_data.source_index = 5'(idx_q[p_q]);
				emit_data.last_result  = run_end && list_end;
			end
			BK_ERR: begin
				emit                  = slot_free;
				emit_data.kind        = KIND_BATCH;
				emit_data.status      = err_q;
				emit_data.last_result = 1'b1;
			end
			default: begin
				emit      = 1'b0;
				emit_data = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == BK_IDLE && hand.load) begin
			key_q  <= nxt_key;
			mat_q  <= nxt_mat;
			mesh_q <= nxt_mesh;
			idx_q  <= nxt_idx;
			n_q    <= hand_count;
			err_q  <= hand.status;
			same_q[0] <= 1'b0;
			for (int i = 1; i < MAX_ITEMS; i++) begin
				same_q[i] <= {nxt_key[i], nxt_mat[i], nxt_mesh[i]} ==
					{nxt_key[i-1], nxt_mat[i-1], nxt_mesh[i-1]};
			end
		end
		if (emit) begin
			out_data_q <= emit_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			start_q     <= '0;
			p_q         <= '0;
			run_last_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			case (state_q)
				BK_IDLE: begin
					start_q <= '0;
					p_q     <= '0;
				end
				BK_SCAN: begin
					if (more) begin
						p_q <= p_q + IW'(1);
					end else begin
						run_last_q <= p_q;
					end
				end
				BK_BATCH: begin
					if (slot_free) begin
						p_q <= start_q;
					end
				end
				BK_INST: begin
					if (slot_free) begin
						p_q <= p_q + IW'(1);
						if (run_end) begin
							start_q <= p_q + IW'(1);
						end
					end
				end
				default: begin
				end
			endcase
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		hand.load |-> state_q == BK_IDLE)
		else $error("list handed over while back is busy");

	a_inst_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == BK_INST |-> p_q <= run_last_q && p_q >= start_q)
		else $error("instance pointer outside its batch");

endmodule

>>> rtl/draw_item_sort_and_batch.sv
// draw item sorter and batcher: an insertion cell row in front, a batch emitter behind
// an item is taken every cycle but a last item waits while the emitter is busy; each
// stored item is placed in sorted order by one compare per cell; after the last item
// the sorted list moves to the emitter; an error result is registered from the error
// state, a batch record after the scan of its batch members
// reset clears counts, flags and the emitter; item_limit returns to 32; stores need none
module draw_item_sort_and_batch import dsb_pkg::*; #(
	parameter int MAX_ITEMS   = 32,
	parameter int HANDLE_BITS = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [5:0] cfg_wdata,
	input  logic       in_valid,
	output logic       in_ready,
	input  item_t      in_data,
	output logic       out_valid,
	input  logic       out_ready,
	output result_t    out_data
);

	localparam int SW = (HANDLE_BITS < 32) ? HANDLE_BITS : 32;
	localparam int IW = $clog2(MAX_ITEMS);
	localparam int CW = $clog2(MAX_ITEMS + 1);

	handoff_t                     hand;
	logic [CW-1:0]                hand_count;
	logic [MAX_ITEMS-1:0][31:0]   nxt_key;
	logic [MAX_ITEMS-1:0][SW-1:0] nxt_mat;
	logic [MAX_ITEMS-1:0][SW-1:0] nxt_mesh;
	logic [MAX_ITEMS-1:0][IW-1:0] nxt_idx;
	logic                         back_busy;

	dsb_front #(.MAX_ITEMS(MAX_ITEMS), .SW(SW), .IW(IW), .CW(CW)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.back_busy  (back_busy),
		.hand       (hand),
		.hand_count (hand_count),
		.nxt_key    (nxt_key),
		.nxt_mat    (nxt_mat),
		.nxt_mesh   (nxt_mesh),
		.nxt_idx    (nxt_idx)
	);

	dsb_back #(.MAX_ITEMS(MAX_ITEMS), .SW(SW), .IW(IW), .CW(CW)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.hand       (hand),
		.hand_count (hand_count),
		.nxt_key    (nxt_key),
		.nxt_mat    (nxt_mat),
		.nxt_mesh   (nxt_mesh),
		.nxt_idx    (nxt_idx),
		.busy       (back_busy),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

endmodule
